>>> rtl/ddo_pkg.sv
// shared types and constants of the differential drive odometry block
// no dependencies; used by ddo_muldiv, ddo_cordic and the top level through scoped names
`timescale 1ns / 1ps

package ddo_pkg;

  localparam int NUM_WHEELS = 4;

  // configuration register indexes
  localparam logic [1:0] REG_WHEEL_RADIUS = 2'd0;
  localparam logic [1:0] REG_INV_WIDTH    = 2'd1;
  localparam logic [1:0] REG_MAX_GAP      = 2'd2;

  localparam logic [15:0] RADIUS_RST    = 16'd17480;
  localparam logic [15:0] INV_WIDTH_RST = 16'd4096;
  localparam logic [31:0] MAX_GAP_RST   = 32'd100000;

  // angles in q3.13 and rad * 2^16
  localparam logic [15:0]        PI_Q13      = 16'd25736;
  localparam logic [15:0]        TWO_PI_Q13  = 16'd51472;
  localparam logic signed [19:0] PI_Q16      = 20'sd205887;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;

  localparam int                 CORDIC_STEPS = 16;
  localparam logic signed [31:0] CORDIC_X0    = 32'sd652032874;
  localparam logic signed [15:0] TRIG_MAX     = 16'sd16384;

  localparam logic signed [15:0] STILL_LIMIT = 16'sd1;

  // rounding divisors and their halves
  localparam logic [31:0] POS_DIV    = 32'd256000000;
  localparam logic [31:0] POS_HALF   = 32'd128000000;
  localparam logic [31:0] ANGLE_DIV  = 32'd125000;
  localparam logic [31:0] ANGLE_HALF = 32'd62500;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_e;

  typedef struct packed {
    logic   start;
    md_op_e op;
  } md_ctrl_t;

  function automatic logic signed [19:0] atan_q16(input logic [3:0] idx);
    logic signed [19:0] r;
    case (idx)
      4'd0:    r = 20'sd51472;
      4'd1:    r = 20'sd30386;
      4'd2:    r = 20'sd16055;
      4'd3:    r = 20'sd8150;
      4'd4:    r = 20'sd4091;
      4'd5:    r = 20'sd2047;
      4'd6:    r = 20'sd1024;
      4'd7:    r = 20'sd512;
      4'd8:    r = 20'sd256;
      4'd9:    r = 20'sd128;
      4'd10:   r = 20'sd64;
      4'd11:   r = 20'sd32;
      4'd12:   r = 20'sd16;
      4'd13:   r = 20'sd8;
      4'd14:   r = 20'sd4;
      default: r = 20'sd2;
    endcase
    return r;
  endfunction

  // speed slot (fl, rl, fr, rr) feeding each joint angle (rl, rr, fl, fr)
  function automatic logic [1:0] joint_src(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd3;
      2'd2:    r = 2'd0;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/ddo_muldiv.sv
// bit-serial multiply and restoring divide unit, one bit per cycle
// depends on ddo_pkg for the control struct and op codes
`timescale 1ns / 1ps

module ddo_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ddo_pkg::md_ctrl_t ctrl_i,
  input  logic [63:0]       opa_i,
  input  logic [31:0]       opb_i,
  output logic              done_o,
  output logic [63:0]       res_o,
  output logic [31:0]       rem_o
);

  localparam logic [5:0] MUL_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST = 6'd63;

  logic             busy_q;
  logic             done_q;
  ddo_pkg::md_op_e  op_q;
  logic [5:0]       cnt_q;
  logic [63:0]      acc_q;
  logic [63:0]      sh_q;
  logic [31:0]      b_q;
  logic [31:0]      rem_q;
  logic [32:0]      trial;
  logic [32:0]      diff;
  logic             fits;

  // partial remainder stays below the divisor, so bit 32 of diff is the borrow
  assign trial = {rem_q, sh_q[63]};
  assign diff  = trial - {1'b0, b_q};
  assign fits  = ~diff[32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ddo_pkg::MD_MUL;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        op_q   <= ctrl_i.op;
        cnt_q  <= (ctrl_i.op == ddo_pkg::MD_DIV) ? DIV_LAST : MUL_LAST;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q <= '0;
      sh_q  <= opa_i;
      b_q   <= opb_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (op_q == ddo_pkg::MD_MUL) begin
        if (b_q[0]) begin
          acc_q <= acc_q + sh_q;
        end
        sh_q <= {sh_q[62:0], 1'b0};
        b_q  <= {1'b0, b_q[31:1]};
      end else begin
        rem_q <= fits ? diff[31:0] : trial[31:0];
        sh_q  <= {sh_q[62:0], fits};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == ddo_pkg::MD_DIV) ? sh_q : acc_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/ddo_cordic.sv
// iterative cordic giving sine and cosine in q1.14, one rotation per cycle
// depends on ddo_pkg for the arctangent table and angle constants
`timescale 1ns / 1ps

module ddo_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [19:0] angle_i,
  output logic               done_o,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);

  localparam logic [3:0] LAST_STEP = 4'(ddo_pkg::CORDIC_STEPS - 1);

  logic               busy_q;
  logic               fin_q;
  logic               done_q;
  logic [3:0]         step_q;
  logic signed [31:0] x_q;
  logic signed [31:0] y_q;
  logic signed [19:0] z_q;
  logic               flip_q;
  logic signed [15:0] sin_q;
  logic signed [15:0] cos_q;
  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic signed [19:0] atan_v;

  // round half away from zero to q1.14 and clamp, sign flipped when folded
  function automatic logic signed [15:0] round14(input logic signed [31:0] v,
                                                 input logic flip);
    logic [31:0] mag;
    logic [32:0] sum;
    logic [16:0] q;
    logic        neg;
    mag = v[31] ? 32'(-v) : 32'(v);
    sum = {1'b0, mag} + 33'd32768;
    q   = sum[32:16];
    if (q > 17'(ddo_pkg::TRIG_MAX)) begin
      q = 17'(ddo_pkg::TRIG_MAX);
    end
    neg = v[31] ^ flip;
    return neg ? 16'(-q) : 16'(q);
  endfunction

  assign xs     = x_q >>> step_q;
  assign ys     = y_q >>> step_q;
  assign atan_v = ddo_pkg::atan_q16(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 4'd1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= ddo_pkg::CORDIC_X0;
      y_q <= '0;
      // fold about +-pi/2
      if (angle_i > ddo_pkg::HALF_PI_Q16) begin
        z_q    <= angle_i - ddo_pkg::PI_Q16;
        flip_q <= 1'b1;
      end else if (angle_i < -ddo_pkg::HALF_PI_Q16) begin
        z_q    <= angle_i + ddo_pkg::PI_Q16;
        flip_q <= 1'b1;
      end else begin
        z_q    <= angle_i;
        flip_q <= 1'b0;
      end
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_v;
      end
    end else if (fin_q) begin
      sin_q <= round14(y_q, flip_q);
      cos_q <= round14(x_q, flip_q);
    end
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

>>> rtl/diff_drive_odometry_integrator_unit.sv
// differential drive odometry integrator, top level
// a rejected gap skips the arithmetic, and a robot that stands still skips the joint
// angle steps; one item in flight, the next accepted once the result is registered,
// and a stalled result holds off the input; one shared bit-serial multiply/divide unit
// reset (async, active low): registers to defaults, pose, twist and angles to zero
// depends on ddo_pkg, ddo_muldiv and ddo_cordic
`timescale 1ns / 1ps

module diff_drive_odometry_integrator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        timestamp_us_i,
  input  logic signed [15:0] front_left_speed_i,
  input  logic signed [15:0] rear_left_speed_i,
  input  logic signed [15:0] front_right_speed_i,
  input  logic signed [15:0] rear_right_speed_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               valid_res_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [15:0] quat_z_o,
  output logic signed [15:0] quat_w_o,
  output logic signed [15:0] linear_velocity_o,
  output logic signed [15:0] angular_velocity_o,
  output logic               moving_o,
  output logic signed [15:0] joint_angle_rear_left_o,
  output logic signed [15:0] joint_angle_rear_right_o,
  output logic signed [15:0] joint_angle_front_left_o,
  output logic signed [15:0] joint_angle_front_right_o
);

  localparam int WIDX_W = $clog2(ddo_pkg::NUM_WHEELS);
  localparam logic [WIDX_W-1:0] LAST_WHEEL = WIDX_W'(ddo_pkg::NUM_WHEELS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_LIN   = 4'd2;
  localparam logic [3:0] S_ANG1  = 4'd3;
  localparam logic [3:0] S_ANG2  = 4'd4;
  localparam logic [3:0] S_TRIG1 = 4'd5;
  localparam logic [3:0] S_DP1   = 4'd6;
  localparam logic [3:0] S_DP2   = 4'd7;
  localparam logic [3:0] S_DP3   = 4'd8;
  localparam logic [3:0] S_STEP1 = 4'd9;
  localparam logic [3:0] S_STEP2 = 4'd10;
  localparam logic [3:0] S_WRAP  = 4'd11;
  localparam logic [3:0] S_TRIG2 = 4'd12;
  localparam logic [3:0] S_PUT   = 4'd13;

  // configuration
  logic [15:0] radius_q;
  logic [15:0] inv_width_q;
  logic [31:0] max_gap_q;

  // odometry state
  logic               started_q;
  logic [31:0]        last_time_q;
  logic [31:0]        pos_x_q;
  logic [31:0]        pos_y_q;
  logic signed [15:0] heading_q;
  logic signed [15:0] twist_lin_q;
  logic signed [15:0] twist_ang_q;
  logic signed [15:0] wa_q [ddo_pkg::NUM_WHEELS];

  // per item work registers
  logic [3:0]         state_q;
  logic signed [15:0] sp_q [ddo_pkg::NUM_WHEELS];
  logic [31:0]        gap_q;
  logic signed [15:0] lin_q;
  logic signed [15:0] ang_q;
  logic               neg_q;
  logic               axis_q;
  logic               tgt_wheel_q;
  logic [WIDX_W-1:0]  widx_q;
  logic               wneg_q;
  logic               moving_q;
  logic               res_ok_q;

  // requests to the arithmetic units
  ddo_pkg::md_ctrl_t  md_ctrl_q;
  logic [63:0]        md_a_q;
  logic [31:0]        md_b_q;
  logic               cs_start_q;
  logic signed [19:0] cs_z_q;

  logic               md_done;
  logic [63:0]        md_res;
  logic [31:0]        md_rem;
  logic               cs_done;
  logic signed [15:0] cs_sin;
  logic signed [15:0] cs_cos;

  // result register
  logic               out_valid_q;
  logic               out_res_q;
  logic [31:0]        out_pos_x_q;
  logic [31:0]        out_pos_y_q;
  logic signed [15:0] out_qz_q;
  logic signed [15:0] out_qw_q;
  logic signed [15:0] out_lin_q;
  logic signed [15:0] out_ang_q;
  logic               out_moving_q;
  logic signed [15:0] out_wa_q [ddo_pkg::NUM_WHEELS];

  logic               in_take;
  logic               out_take;
  logic               out_free;
  logic [31:0]        gap_d;
  logic signed [16:0] sum_l;
  logic signed [16:0] sum_r;
  logic signed [17:0] sum_all;
  logic signed [17:0] sum_diff;
  logic [17:0]        all_mag;
  logic [17:0]        diff_mag;
  logic [35:0]        lin_rnd;
  logic [50:0]        ang_rnd;
  logic [31:0]        lin_mag;
  logic [31:0]        ang_mag;
  logic [31:0]        dp_delta;
  logic signed [15:0] step_base;
  logic signed [33:0] step_mag;
  logic signed [33:0] step_sum;
  logic [33:0]        wrap_mag;
  logic [15:0]        wrap_rem;
  logic [15:0]        wrap_pos;
  logic signed [15:0] wrap_val;
  logic               moving_d;
  logic [WIDX_W-1:0]  nxt_widx;
  logic signed [15:0] nxt_speed;

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic signed [15:0] sat16(input logic neg, input logic [31:0] mag);
    logic signed [15:0] r;
    if (!neg) begin
      r = (mag > 32'd32767) ? 16'sh7fff : 16'(mag);
    end else begin
      r = (mag > 32'd32768) ? 16'sh8000 : 16'(-mag);
    end
    return r;
  endfunction

  function automatic logic signed [19:0] z_times8(input logic signed [15:0] h);
    return {h[15], h, 3'b000};
  endfunction

  function automatic logic signed [19:0] z_times4(input logic signed [15:0] h);
    return {h[15], h[15], h, 2'b00};
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i & ~in_stall_o;
  assign out_take   = out_valid_q & ~out_stall_i;
  assign out_free   = ~out_valid_q | out_take;

  assign gap_d = started_q ? (timestamp_us_i - last_time_q) : '0;

  // wheel sums and rounding of the twist products
  assign sum_l    = 17'(sp_q[0]) + 17'(sp_q[1]);
  assign sum_r    = 17'(sp_q[2]) + 17'(sp_q[3]);
  assign sum_all  = 18'(sum_l) + 18'(sum_r);
  assign sum_diff = 18'(sum_r) - 18'(sum_l);
  assign all_mag  = sum_all[17] ? 18'(-sum_all) : 18'(sum_all);
  assign diff_mag = sum_diff[17] ? 18'(-sum_diff) : 18'(sum_diff);
  assign lin_rnd  = md_res[35:0] + 36'h0_0002_0000;
  assign ang_rnd  = md_res[50:0] + (51'd1 << 28);
  assign lin_mag  = {14'd0, lin_rnd[35:18]};
  assign ang_mag  = {10'd0, ang_rnd[50:29]};

  assign dp_delta = neg_q ? (32'd0 - md_res[31:0]) : md_res[31:0];

  // angle step: base plus rounded increment, then offset by pi for the wrap
  assign step_base = tgt_wheel_q ? wa_q[widx_q] : heading_q;
  assign step_mag  = signed'({2'b00, md_res[31:0]});
  assign step_sum  = 34'(step_base) + (neg_q ? -step_mag : step_mag)
                     + signed'(34'(ddo_pkg::PI_Q13));
  assign wrap_mag  = step_sum[33] ? 34'(-step_sum) : 34'(step_sum);
  assign wrap_rem  = md_rem[15:0];
  assign wrap_pos  = (wneg_q && (wrap_rem != '0)) ? (ddo_pkg::TWO_PI_Q13 - wrap_rem)
                                                  : wrap_rem;
  assign wrap_val  = signed'(wrap_pos - ddo_pkg::PI_Q13);

  assign moving_d = (lin_q > ddo_pkg::STILL_LIMIT) || (lin_q < -ddo_pkg::STILL_LIMIT) ||
                    (ang_q > ddo_pkg::STILL_LIMIT) || (ang_q < -ddo_pkg::STILL_LIMIT);

  assign nxt_widx  = tgt_wheel_q ? (widx_q + WIDX_W'(1)) : '0;
  assign nxt_speed = sp_q[ddo_pkg::joint_src(nxt_widx)];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= ddo_pkg::RADIUS_RST;
      inv_width_q <= ddo_pkg::INV_WIDTH_RST;
      max_gap_q   <= ddo_pkg::MAX_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ddo_pkg::REG_WHEEL_RADIUS: radius_q    <= cfg_data_i[15:0];
        ddo_pkg::REG_INV_WIDTH:    inv_width_q <= cfg_data_i[15:0];
        ddo_pkg::REG_MAX_GAP:      max_gap_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= 1'b0;
      last_time_q <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
      twist_lin_q <= '0;
      twist_ang_q <= '0;
      for (int k = 0; k < ddo_pkg::NUM_WHEELS; k++) begin
        wa_q[k] <= '0;
        sp_q[k] <= '0;
      end
      gap_q       <= '0;
      lin_q       <= '0;
      ang_q       <= '0;
      neg_q       <= 1'b0;
      axis_q      <= 1'b0;
      tgt_wheel_q <= 1'b0;
      widx_q      <= '0;
      wneg_q      <= 1'b0;
      moving_q    <= 1'b0;
      res_ok_q    <= 1'b0;
      md_ctrl_q   <= '{start: 1'b0, op: ddo_pkg::MD_MUL};
      md_a_q      <= '0;
      md_b_q      <= '0;
      cs_start_q  <= 1'b0;
      cs_z_q      <= '0;
    end else begin
      md_ctrl_q.start <= 1'b0;
      cs_start_q      <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_take) begin
            sp_q[0]     <= front_left_speed_i;
            sp_q[1]     <= rear_left_speed_i;
            sp_q[2]     <= front_right_speed_i;
            sp_q[3]     <= rear_right_speed_i;
            gap_q       <= gap_d;
            started_q   <= 1'b1;
            last_time_q <= timestamp_us_i;
            state_q     <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (gap_q > max_gap_q) begin
            res_ok_q <= 1'b0;
            state_q  <= S_PUT;
          end else begin
            md_ctrl_q <= '{start: 1'b1, op: ddo_pkg::MD_MUL};
            md_a_q    <= 64'(all_mag);
            md_b_q    <= 32'(radius_q);
            state_q   <= S_LIN;
          end
        end
        S_LIN: begin
          if (md_done) begin
            lin_q     <= sat16(sum_all[17], lin_mag);
            md_ctrl_q <= '{start: 1'b1, op: ddo_pkg::MD_MUL};
            md_a_q    <= 64'(diff_mag);
            md_b_q    <= 32'(radius_q);
            state_q   <= S_ANG1;
          end
        end
        S_ANG1: begin
          if (md_done) begin
            md_ctrl_q <= '{start: 1'b1, op: ddo_pkg::MD_MUL};
            md_a_q    <= md_res;
            md_b_q    <= 32'(inv_width_q);
            state_q   <= S_ANG2;
          end
        end
        S_ANG2: begin
          if (md_done) begin
            ang_q      <= sat16(sum_diff[17], ang_mag);
            cs_start_q <= 1'b1;
            cs_z_q     <= z_times8(heading_q);
            state_q    <= S_TRIG1;
          end
        end
        S_TRIG1: begin
          if (cs_done) begin
            md_ctrl_q <= '{start: 1'b1, op: ddo_pkg::MD_MUL};
            md_a_q    <= 64'(mag16(cs_cos));
            md_b_q    <= 32'(mag16(twist_lin_q));
            neg_q     <= cs_cos[15] ^ twist_lin_q[15];
            axis_q    <= 1'b0;
            state_q   <= S_DP1;
          end
        end
        S_DP1: begin
          if (md_done) begin
            md_ctrl_q <= '{start: 1'b1, op: ddo_pkg::MD_MUL};
            md_a_q    <= md_res;
            md_b_q    <= gap_q;
            state_q   <= S_DP2;
          end
        end
        S_DP2: begin
          if (md_done) begin
            md_ctrl_q <= '{start: 1'b1, op: ddo_pkg::MD_DIV};
            md_a_q    <= md_res + 64'(ddo_pkg::POS_HALF);
            md_b_q    <= ddo_pkg::POS_DIV;
            state_q   <= S_DP3;
          end
        end
        S_DP3: begin
          if (md_done) begin
            md_ctrl_q <= '{start: 1'b1, op: ddo_pkg::MD_MUL};
            if (!axis_q) begin
              pos_x_q <= pos_x_q + dp_delta;
              md_a_q  <= 64'(mag16(cs_sin));
              md_b_q  <= 32'(mag16(twist_lin_q));
              neg_q   <= cs_sin[15] ^ twist_lin_q[15];
              axis_q  <= 1'b1;
              state_q <= S_DP1;
            end else begin
              // yaw step from the yaw rate held before this item
              pos_y_q     <= pos_y_q + dp_delta;
              md_a_q      <= 64'(mag16(twist_ang_q));
              md_b_q      <= gap_q;
              neg_q       <= twist_ang_q[15];
              tgt_wheel_q <= 1'b0;
              state_q     <= S_STEP1;
            end
          end
        end
        S_STEP1: begin
          if (md_done) begin
            md_ctrl_q <= '{start: 1'b1, op: ddo_pkg::MD_DIV};
            md_a_q    <= md_res + 64'(ddo_pkg::ANGLE_HALF);
            md_b_q    <= ddo_pkg::ANGLE_DIV;
            state_q   <= S_STEP2;
          end
        end
        S_STEP2: begin
          if (md_done) begin
            wneg_q    <= step_sum[33];
            md_ctrl_q <= '{start: 1'b1, op: ddo_pkg::MD_DIV};
            md_a_q    <= 64'(wrap_mag);
            md_b_q    <= 32'(ddo_pkg::TWO_PI_Q13);
            state_q   <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (md_done) begin
            if (!tgt_wheel_q) begin
              heading_q   <= wrap_val;
              twist_lin_q <= lin_q;
              twist_ang_q <= ang_q;
              moving_q    <= moving_d;
              if (moving_d) begin
                md_ctrl_q   <= '{start: 1'b1, op: ddo_pkg::MD_MUL};
                md_a_q      <= 64'(mag16(nxt_speed));
                md_b_q      <= gap_q;
                neg_q       <= nxt_speed[15];
                widx_q      <= nxt_widx;
                tgt_wheel_q <= 1'b1;
                state_q     <= S_STEP1;
              end else begin
                cs_start_q <= 1'b1;
                cs_z_q     <= z_times4(wrap_val);
                state_q    <= S_TRIG2;
              end
            end else begin
              wa_q[widx_q] <= wrap_val;
              if (widx_q == LAST_WHEEL) begin
                cs_start_q <= 1'b1;
                cs_z_q     <= z_times4(heading_q);
                state_q    <= S_TRIG2;
              end else begin
                md_ctrl_q <= '{start: 1'b1, op: ddo_pkg::MD_MUL};
                md_a_q    <= 64'(mag16(nxt_speed));
                md_b_q    <= gap_q;
                neg_q     <= nxt_speed[15];
                widx_q    <= nxt_widx;
                state_q   <= S_STEP1;
              end
            end
          end
        end
        S_TRIG2: begin
          if (cs_done) begin
            res_ok_q <= 1'b1;
            state_q  <= S_PUT;
          end
        end
        S_PUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result register, a rejected gap gives an all zero item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_PUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_PUT) && out_free) begin
      out_res_q    <= res_ok_q;
      out_pos_x_q  <= res_ok_q ? pos_x_q : '0;
      out_pos_y_q  <= res_ok_q ? pos_y_q : '0;
      out_qz_q     <= res_ok_q ? cs_sin : '0;
      out_qw_q     <= res_ok_q ? cs_cos : '0;
      out_lin_q    <= res_ok_q ? twist_lin_q : '0;
      out_ang_q    <= res_ok_q ? twist_ang_q : '0;
      out_moving_q <= res_ok_q & moving_q;
      for (int k = 0; k < ddo_pkg::NUM_WHEELS; k++) begin
        out_wa_q[k] <= res_ok_q ? wa_q[k] : '0;
      end
    end
  end

  ddo_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (md_ctrl_q),
    .opa_i  (md_a_q),
    .opb_i  (md_b_q),
    .done_o (md_done),
    .res_o  (md_res),
    .rem_o  (md_rem)
  );

  ddo_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cs_start_q),
    .angle_i (cs_z_q),
    .done_o  (cs_done),
    .sin_o   (cs_sin),
    .cos_o   (cs_cos)
  );

  assign out_valid_o               = out_valid_q;
  assign valid_res_o               = out_res_q;
  assign pos_x_o                   = out_pos_x_q;
  assign pos_y_o                   = out_pos_y_q;
  assign quat_z_o                  = out_qz_q;
  assign quat_w_o                  = out_qw_q;
  assign linear_velocity_o         = out_lin_q;
  assign angular_velocity_o        = out_ang_q;
  assign moving_o                  = out_moving_q;
  assign joint_angle_rear_left_o   = out_wa_q[0];
  assign joint_angle_rear_right_o  = out_wa_q[1];
  assign joint_angle_front_left_o  = out_wa_q[2];
  assign joint_angle_front_right_o = out_wa_q[3];

endmodule

>>> rtl/ddo_checker.sv
// port level checks of the odometry integrator, bound to the top level
// depends on diff_drive_odometry_integrator_unit port names only
`timescale 1ns / 1ps

module ddo_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               valid_res_o,
  input logic signed [31:0] pos_x_o,
  input logic signed [31:0] pos_y_o,
  input logic signed [15:0] quat_z_o,
  input logic signed [15:0] quat_w_o,
  input logic signed [15:0] linear_velocity_o,
  input logic signed [15:0] angular_velocity_o,
  input logic               moving_o
);

  // a stalled item stays valid and keeps its position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pos_x_o) && $stable(pos_y_o))
    else $error("stalled item changed");

  // one item at a time: an accepted item closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after accept");

  // a rejected gap gives zero position, twist and moving flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> pos_x_o == 0 && pos_y_o == 0 &&
      linear_velocity_o == 0 && angular_velocity_o == 0 && !moving_o)
    else $error("rejected item not zero");

  // standing still means both twist values within one lsb
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o && !moving_o |->
      linear_velocity_o <= 16'sd1 && linear_velocity_o >= -16'sd1 &&
      angular_velocity_o <= 16'sd1 && angular_velocity_o >= -16'sd1)
    else $error("moving flag disagrees with twist");

  // quaternion parts stay within unit range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> quat_z_o <= 16'sd16384 && quat_z_o >= -16'sd16384 &&
      quat_w_o <= 16'sd16384 && quat_w_o >= -16'sd16384)
    else $error("quaternion out of range");

endmodule

bind diff_drive_odometry_integrator_unit ddo_checker u_ddo_checker (.*);
